@@ rtl/mfc_pkg.sv @@
// shared types, codes and the crc-8 step for the motor feedback frame checker
// no dependencies; imported by the parser, the result buffer, the top level and the testbench
package mfc_pkg;

    localparam int          FRAME_LEN = 10;
    localparam int          CRC_SPAN  = 9;
    localparam logic [7:0]  CRC_POLY  = 8'h8C;
    localparam logic [7:0]  CMD_READ  = 8'h74;
    localparam logic [15:0] TIMEOUT_RESET = 16'd20;

    localparam int CNT_W  = $clog2(FRAME_LEN);
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 1;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_TICK  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SHORT    = 2'd1,
        STATUS_CRC_ERR  = 2'd2,
        STATUS_MISMATCH = 2'd3
    } status_t;

    typedef enum logic [CIDX_W-1:0] {
        REG_MOTOR_ID = 1'b0,
        REG_TIMEOUT  = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [7:0]  motor_id;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] laps;
        logic [15:0]        turn_position;
        logic [7:0]         fault;
    } result_t;

    // handshake state between the result buffer and the front end
    typedef struct packed {
        logic full;
        logic skid_used;
    } buf_status_t;

    // reflected crc-8, lsb first, one byte per call
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

@@ rtl/mfc_item_if.sv @@
// valid/ready channel carrying one input transaction (mode and received byte)
// depends on nothing
interface mfc_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

@@ rtl/mfc_result_if.sv @@
// valid/ready channel carrying one result transaction of the frame checker
// depends on nothing
interface mfc_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] laps;
    logic [15:0]        turn_position;
    logic [7:0]         fault;

    modport source (output valid, output status, output laps, output turn_position,
                    output fault, input ready);
    modport sink   (input valid, input status, input laps, input turn_position,
                    input fault, output ready);
endinterface

@@ rtl/mfc_parser.sv @@
// frame state, byte store, crc and result decode of the frame checker
// depends on mfc_pkg
module mfc_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [1:0]      mode,
    input  logic [7:0]      rx_byte,
    input  mfc_pkg::cfg_t   cfg,
    output logic            res_valid,
    output mfc_pkg::result_t res
);
    import mfc_pkg::*;

    logic             waiting_reg, waiting_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       crc_reg, crc_next;
    logic [15:0]      tick_reg, tick_next;
    logic [7:0]       frame_reg [CRC_SPAN];
    logic             frame_we;
    logic [16:0]      tick_sum;

    assign tick_sum = {1'b0, tick_reg} + 17'd1;

    always_comb
    begin
        waiting_next = waiting_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        tick_next    = tick_reg;
        frame_we     = 1'b0;
        res_valid    = 1'b0;
        res          = '{status: STATUS_OK, laps: '0, turn_position: '0, fault: '0};
        if (fire)
        begin
            case (mode_t'(mode))
                MODE_START:
                begin
                    waiting_next = 1'b1;
                    count_next   = '0;
                    crc_next     = '0;
                    tick_next    = '0;
                end
                MODE_BYTE:
                begin
                    if (waiting_reg)
                    begin
                        if (count_reg < CNT_W'(CRC_SPAN))
                        begin
                            frame_we   = 1'b1;
                            crc_next   = crc8_update(crc_reg, rx_byte);
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            // last byte carries the crc
                            waiting_next = 1'b0;
                            count_next   = '0;
                            res_valid    = 1'b1;
                            if (crc_reg != rx_byte)
                                res.status = STATUS_CRC_ERR;
                            else if (frame_reg[0] != cfg.motor_id || frame_reg[1] != CMD_READ)
                                res.status = STATUS_MISMATCH;
                            else
                            begin
                                res.laps = $signed({frame_reg[2], frame_reg[3],
                                                    frame_reg[4], frame_reg[5]});
                                res.turn_position = {frame_reg[6], frame_reg[7]};
                                res.fault         = frame_reg[8];
                            end
                        end
                    end
                end
                MODE_TICK:
                begin
                    if (waiting_reg)
                    begin
                        tick_next = tick_sum[15:0];
                        // a timeout of zero acts like one
                        if (tick_sum >= {1'b0, cfg.timeout_ticks})
                        begin
                            waiting_next = 1'b0;
                            count_next   = '0;
                            res_valid    = 1'b1;
                            res.status   = STATUS_SHORT;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg <= 1'b0;
            count_reg   <= '0;
            crc_reg     <= '0;
            tick_reg    <= '0;
        end
        else
        begin
            waiting_reg <= waiting_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            tick_reg    <= tick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_we)
            frame_reg[count_reg] <= rx_byte;
    end

endmodule

@@ rtl/mfc_out_buf.sv @@
// two-entry result buffer (output register plus skid register)
// depends on mfc_pkg
module mfc_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mfc_pkg::result_t      push_data,
    input  logic                  pop_ready,
    output mfc_pkg::result_t      head,
    output mfc_pkg::buf_status_t  stat
);
    import mfc_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop = main_valid_reg & pop_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // front end is held off while the skid entry is used
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
            main_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign head           = main_reg;
    assign stat.full      = main_valid_reg;
    assign stat.skid_used = skid_valid_reg;

endmodule

@@ rtl/motor_feedback_frame_checker.sv @@
// top level of the motor feedback frame checker: config registers, parser, result buffer
// depends on mfc_pkg, mfc_item_if, mfc_result_if, mfc_parser, mfc_out_buf
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+-------------------------------------------
//   item     | in  | valid/ready  | mode[1:0], rx_byte[7:0]
//   result   | out | valid/ready  | status[1:0], laps[31:0] s, turn_position[15:0],
//            |     |              | fault[7:0]
//   cfg      | in  | write enable | cfg_index[0] (0 motor_id, 1 timeout_ticks), cfg_data[15:0]
//
// one transaction per cycle while item.ready is high; each result is registered into the output or skid register
// the crc step and the frame decode sit between the frame state and the result buffer
// reset closes the wait window; motor_id resets to 0, timeout_ticks to 20
// item.ready is low for as long as the skid entry holds a result
module motor_feedback_frame_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [mfc_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [mfc_pkg::CFG_W-1:0]    cfg_data,
    mfc_item_if.sink                     item,
    mfc_result_if.source                 result
);
    import mfc_pkg::*;

    cfg_t        cfg_reg;
    logic        fire;
    logic        res_valid;
    result_t     res;
    result_t     head;
    buf_status_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motor_id      <= '0;
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MOTOR_ID: cfg_reg.motor_id      <= cfg_data[7:0];
                REG_TIMEOUT:  cfg_reg.timeout_ticks <= cfg_data[15:0];
                default:      cfg_reg               <= cfg_reg;
            endcase
        end
    end

    assign item.ready = !stat.skid_used;
    assign fire       = item.valid & item.ready;

    mfc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .mode      (item.mode),
        .rx_byte   (item.rx_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    mfc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop_ready (result.ready),
        .head      (head),
        .stat      (stat)
    );

    assign result.valid         = stat.full;
    assign result.status        = head.status;
    assign result.laps          = head.laps;
    assign result.turn_position = head.turn_position;
    assign result.fault         = head.fault;

    // skid entry only in use behind a full output register
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> result.valid)
        else $error("skid entry used while output register empty");

    // failed checks carry zero fields
    a_fail_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status != STATUS_OK) |->
            (result.laps == 32'sd0 && result.turn_position == 16'd0 && result.fault == 8'd0))
        else $error("non-ok result with nonzero fields");

    // a start transaction never produces a result
    a_start_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.mode == MODE_START) |-> !res_valid)
        else $error("start transaction produced a result");

    // a result is only produced by an accepted transaction
    a_result_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> fire)
        else $error("result produced without an accepted transaction");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for motor_feedback_frame_checker: directed frames, then random
// frame traffic over several register settings with random stalls on both channels
// depends on mfc_pkg, mfc_item_if, mfc_result_if and the rtl of the block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mfc_pkg::*;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS  = 850;
    localparam int         PHASES        = 6;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         QUIET_LIMIT   = 2000;
    localparam int         PRINT_LIMIT   = 100;

    class FeedbackScoreboard;
        logic [7:0]  motor_id;
        logic [15:0] timeout_ticks;
        bit          window_open;
        logic [3:0]  byte_count;
        logic [7:0]  crc_acc;
        logic [15:0] tick_count;
        logic [7:0]  frame_bytes [FRAME_LEN];
        result_t     expected_results [$];
        int          mismatches;

        function new();
            motor_id      = 8'h00;
            timeout_ticks = TIMEOUT_RESET;
            window_open   = 1'b0;
            byte_count    = '0;
            crc_acc       = '0;
            tick_count    = '0;
            mismatches    = 0;
        endfunction

        // reflected crc-8, one byte, lsb first
        static function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
            logic [7:0] c;
            c = crc ^ b;
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            return c;
        endfunction

        function void write_reg(reg_index_t idx, logic [15:0] val);
            if (idx == REG_MOTOR_ID)
                motor_id = val[7:0];
            else
                timeout_ticks = val;
        endfunction

        function void push_result(status_t st, logic signed [31:0] laps,
                                  logic [15:0] pos, logic [7:0] flt);
            result_t r;
            r.status        = st;
            r.laps          = laps;
            r.turn_position = pos;
            r.fault         = flt;
            expected_results.push_back(r);
        endfunction

        function void note_item(logic [1:0] mode, logic [7:0] b);
            if (mode == MODE_START)
            begin
                window_open = 1'b1;
                byte_count  = '0;
                crc_acc     = '0;
                tick_count  = '0;
            end
            else if (window_open && mode == MODE_BYTE)
            begin
                if (byte_count < CRC_SPAN)
                begin
                    frame_bytes[byte_count] = b;
                    crc_acc = crc_step(crc_acc, b);
                    byte_count++;
                end
                else
                begin
                    frame_bytes[CRC_SPAN] = b;
                    window_open = 1'b0;
                    byte_count  = '0;
                    if (crc_acc != b)
                        push_result(STATUS_CRC_ERR, '0, '0, '0);
                    else if (frame_bytes[0] != motor_id || frame_bytes[1] != CMD_READ)
                        push_result(STATUS_MISMATCH, '0, '0, '0);
                    else
                        push_result(STATUS_OK,
                                    {frame_bytes[2], frame_bytes[3],
                                     frame_bytes[4], frame_bytes[5]},
                                    {frame_bytes[6], frame_bytes[7]}, frame_bytes[8]);
                end
            end
            else if (window_open && mode == MODE_TICK)
            begin
                tick_count++;
                // a zero timeout behaves like one: the first tick closes the window
                if (tick_count >= timeout_ticks)
                begin
                    window_open = 1'b0;
                    byte_count  = '0;
                    push_result(STATUS_SHORT, '0, '0, '0);
                end
            end
        endfunction

        task report(string msg);
            if (mismatches < PRINT_LIMIT)
                $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [1:0] status, logic signed [31:0] laps,
                          logic [15:0] pos, logic [7:0] flt);
            result_t want;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result with nothing expected, status %0d", status));
                return;
            end
            want = expected_results.pop_front();
            if (status !== want.status)
                report($sformatf("status got %0d want %0d", status, want.status));
            if (laps !== want.laps)
                report($sformatf("laps got %0d want %0d", laps, want.laps));
            if (pos !== want.turn_position)
                report($sformatf("turn_position got %0d want %0d", pos, want.turn_position));
            if (flt !== want.fault)
                report($sformatf("fault got %0d want %0d", flt, want.fault));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CIDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    mfc_item_if   item_ch ();
    mfc_result_if result_ch ();

    motor_feedback_frame_checker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    FeedbackScoreboard sb;
    int                quiet_cycles = 0;
    int                items_sent;
    bit                no_idle;
    logic [7:0]        cur_id;
    logic [15:0]       cur_timeout;
    logic [7:0]        frame_buf [FRAME_LEN];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // monitor: results are checked before the transaction of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.status, result_ch.laps,
                                result_ch.turn_position, result_ch.fault);
            if (item_ch.valid && item_ch.ready)
                sb.note_item(item_ch.mode, item_ch.rx_byte);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    function automatic int draw_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    // result side: random stall before each transaction
    initial
    begin
        int gap;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid) @(posedge clk);
        end
    end

    // valid stays high after a transaction until the next call or stop_items
    task automatic send_item(input logic [1:0] m, input logic [7:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.mode    <= m;
        item_ch.rx_byte <= b;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic stop_items();
        item_ch.valid <= 1'b0;
    endtask

    task automatic drain_results();
        stop_items();
        @(posedge clk);
        while (sb.expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic load_reg(input reg_index_t idx, input logic [15:0] val);
        drain_results();
        // a byte or tick that gives no result is not drained, so let the last one settle
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_config(input logic [7:0] id, input logic [15:0] ticks);
        load_reg(REG_MOTOR_ID, {8'h00, id});
        load_reg(REG_TIMEOUT, ticks);
        cur_id      = id;
        cur_timeout = ticks;
    endtask

    function automatic void build_frame(input logic [7:0] id, input logic [7:0] cmd,
                                        input logic [31:0] laps, input logic [15:0] pos,
                                        input logic [7:0] flt);
        logic [7:0] crc;
        frame_buf[0] = id;
        frame_buf[1] = cmd;
        frame_buf[2] = laps[31:24];
        frame_buf[3] = laps[23:16];
        frame_buf[4] = laps[15:8];
        frame_buf[5] = laps[7:0];
        frame_buf[6] = pos[15:8];
        frame_buf[7] = pos[7:0];
        frame_buf[8] = flt;
        crc = '0;
        for (int k = 0; k < CRC_SPAN; k++)
            crc = FeedbackScoreboard::crc_step(crc, frame_buf[k]);
        frame_buf[CRC_SPAN] = crc;
    endfunction

    // mostly well-formed, with an occasional wrong id, command or crc
    function automatic void random_frame();
        logic [7:0] id;
        logic [7:0] cmd;
        id  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cur_id;
        cmd = ($urandom_range(0, 9) == 0) ? 8'($urandom) : CMD_READ;
        build_frame(id, cmd, $urandom, 16'($urandom), 8'($urandom));
        if ($urandom_range(0, 9) == 0)
            frame_buf[CRC_SPAN] ^= 8'($urandom_range(1, 255));
    endfunction

    task automatic send_frame(input int n_bytes, input int tick_pct);
        send_item(MODE_START, 8'($urandom));
        for (int k = 0; k < n_bytes; k++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                send_item(MODE_TICK, 8'($urandom));
            send_item(MODE_BYTE, frame_buf[k]);
        end
    endtask

    task automatic random_burst();
        int pick;
        int n;
        pick    = $urandom_range(0, 99);
        no_idle = ($urandom_range(0, 4) == 0);
        if (pick < 60)
        begin
            random_frame();
            send_frame(FRAME_LEN, 5);
        end
        else if (pick < 72)
        begin
            // short reply, then ticks toward the timeout
            random_frame();
            send_frame($urandom_range(0, CRC_SPAN), 0);
            if (cur_timeout <= 40)
                n = ((cur_timeout == 0) ? 1 : int'(cur_timeout)) + $urandom_range(0, 1);
            else
                n = $urandom_range(1, 5);
            repeat (n) send_item(MODE_TICK, 8'($urandom));
        end
        else if (pick < 82)
        begin
            // start again in the middle of a frame
            random_frame();
            send_frame($urandom_range(1, CRC_SPAN), 0);
            random_frame();
            send_frame(FRAME_LEN, 5);
        end
        else if (pick < 95)
        begin
            n = $urandom_range(1, 4);
            repeat (n) send_item(2'($urandom_range(0, 3)), 8'($urandom));
        end
        else
            drain_results();
    endtask

    initial
    begin
        int phase_start;
        sb          = new();
        items_sent  = 0;
        no_idle     = 1'b0;
        cur_id      = 8'h00;
        cur_timeout = TIMEOUT_RESET;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_MOTOR_ID;
        cfg_data        <= '0;
        item_ch.valid   <= 1'b0;
        item_ch.mode    <= MODE_START;
        item_ch.rx_byte <= 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // no window open yet: these are dropped
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_TICK, 8'h00);
        // good frame against the reset motor id
        build_frame(8'h00, CMD_READ, 32'h8000_0000, 16'hFFFF, 8'hFF);
        send_frame(FRAME_LEN, 0);

        set_config(8'hFF, 16'd0);
        // restart mid-frame, unused mode, then a zero timeout on the first tick
        send_item(MODE_START, 8'h00);
        send_item(MODE_BYTE, 8'h12);
        send_item(MODE_START, 8'hFF);
        send_item(MODE_UNUSED, 8'h5A);
        send_item(MODE_TICK, 8'hFF);
        // valid crc but wrong command byte
        build_frame(8'hFF, 8'h00, 32'h7FFF_FFFF, 16'h0000, 8'h00);
        send_frame(FRAME_LEN, 0);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       set_config(8'($urandom), TIMEOUT_RESET);
                1:       set_config(8'h00, 16'd1);
                2:       set_config(8'hFF, 16'hFFFF);
                3:       set_config(8'($urandom), 16'($urandom_range(2, 40)));
                4:       set_config(8'($urandom), 16'd0);
                default: set_config(8'($urandom), 16'($urandom_range(5, 30)));
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < RANDOM_ITEMS / PHASES)
                random_burst();
        end

        no_idle = 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
